FILE: rtl/core/rcpv_pkg.sv
package rcpv_pkg;

    // default pulse measurement width, microseconds
    localparam int PULSE_BITS_DEF = 15;

    localparam int TOP_BITS     = 10;
    localparam int VEL_BITS     = 11;
    localparam int CFG_IDX_BITS = 3;

    // quotient bits per divide: one overflow bit above an 11 bit magnitude
    localparam int QUOT_BITS = 12;

    localparam int VEL_LIMIT  = 1000;
    localparam int SPIN_CENTI = 50;

    // register reset values
    localparam int PULSE_MIN_RST   = 993;
    localparam int PULSE_MAX_RST   = 2000;
    localparam int PULSE_MID_RST   = 1500;
    localparam int DEAD_LOW_RST    = 1450;
    localparam int DEAD_HIGH_RST   = 1550;
    localparam int SPAN_MARGIN_RST = 10;
    localparam int TOP_LINEAR_RST  = 200;
    localparam int TOP_ANGULAR_RST = 400;

    typedef enum logic [1:0] {
        OP_STOP   = 2'd0,
        OP_MANUAL = 2'd1,
        OP_AUTO   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PULSE_MIN   = 3'd0,
        CFG_PULSE_MAX   = 3'd1,
        CFG_PULSE_MID   = 3'd2,
        CFG_DEAD_LOW    = 3'd3,
        CFG_DEAD_HIGH   = 3'd4,
        CFG_SPAN_MARGIN = 3'd5,
        CFG_TOP_LINEAR  = 3'd6,
        CFG_TOP_ANGULAR = 3'd7
    } t_cfg_idx;

endpackage

FILE: rtl/core/rcpv_in_if.sv
interface rcpv_in_if import rcpv_pkg::*; #(
    parameter int PULSE_BITS = PULSE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PULSE_BITS-1:0] mode_pulse;
    logic [PULSE_BITS-1:0] limit_pulse;
    logic [PULSE_BITS-1:0] linear_pulse;
    logic [PULSE_BITS-1:0] turn_pulse;
    logic [PULSE_BITS-1:0] spin_pulse;

    modport source (
        output valid, mode_pulse, limit_pulse, linear_pulse, turn_pulse, spin_pulse,
        input  ready
    );
    modport sink (
        input  valid, mode_pulse, limit_pulse, linear_pulse, turn_pulse, spin_pulse,
        output ready
    );
endinterface

FILE: rtl/core/rcpv_out_if.sv
interface rcpv_out_if import rcpv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op_mode;
    logic                       mode_changed;
    logic                       velocity_valid;
    logic signed [VEL_BITS-1:0] linear_centi;
    logic signed [VEL_BITS-1:0] angular_centi;

    modport source (
        output valid, op_mode, mode_changed, velocity_valid, linear_centi, angular_centi,
        input  ready
    );
    modport sink (
        input  valid, op_mode, mode_changed, velocity_valid, linear_centi, angular_centi,
        output ready
    );
endinterface

FILE: rtl/core/rcpv_mul.sv
module rcpv_mul import rcpv_pkg::*; #(
    parameter int AW = 27,
    parameter int BW = 19
) (
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    // shared signed multiplier, product registered by the sequencer
    assign o_p = (AW+BW)'(i_a) * (AW+BW)'(i_b);
endmodule

FILE: rtl/core/rcpv_div_step.sv
module rcpv_div_step import rcpv_pkg::*; #(
    parameter int NW = 45
) (
    input  logic [NW-1:0] i_rem,
    input  logic [NW-1:0] i_dsh,
    output logic [NW-1:0] o_rem,
    output logic          o_bit
);
    // one restoring step: subtract the aligned divisor when it fits
    always_comb begin
        o_bit = (i_rem >= i_dsh);
        o_rem = o_bit ? (i_rem - i_dsh) : i_rem;
    end
endmodule

FILE: rtl/core/rcpv_core.sv
module rcpv_core import rcpv_pkg::*; #(
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [PULSE_BITS-1:0]      i_limit,
    input  logic [PULSE_BITS-1:0]      i_lin,
    input  logic [PULSE_BITS-1:0]      i_turn,
    input  logic [PULSE_BITS-1:0]      i_spin,
    input  logic [PULSE_BITS-1:0]      i_pulse_min,
    input  logic [PULSE_BITS-1:0]      i_pulse_max,
    input  logic [PULSE_BITS-1:0]      i_pulse_mid,
    input  logic [PULSE_BITS-1:0]      i_dead_low,
    input  logic [PULSE_BITS-1:0]      i_dead_high,
    input  logic [TOP_BITS-1:0]        i_span_margin,
    input  logic [TOP_BITS-1:0]        i_top_linear,
    input  logic [TOP_BITS-1:0]        i_top_angular,
    output logic                       o_done,
    output logic signed [VEL_BITS-1:0] o_lin,
    output logic signed [VEL_BITS-1:0] o_ang
);
    localparam int LW = PULSE_BITS + 2;       // lo, span, limit - lo
    localparam int BW = PULSE_BITS + 4;       // stick term
    localparam int AW = PULSE_BITS + 12;      // top * (limit - lo)
    localparam int PW = AW + BW;              // product
    localparam int DW = 2 * PULSE_BITS + 2;   // span squared
    localparam int NW = 2 * PULSE_BITS + 15;  // numerator magnitude
    localparam int CW = $clog2(QUOT_BITS);

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQ,
        C_TA,
        C_NUM,
        C_DIV,
        C_FIN
    } t_cstate;

    t_cstate r_state;
    logic    r_done;
    logic    r_sel;     // 0 linear stick, 1 turn stick

    logic [PULSE_BITS-1:0] r_limit, r_lin, r_turn, r_spin;
    logic [DW-1:0]         r_den;
    logic                  r_span0;
    logic signed [AW-1:0]  r_ta;
    logic                  r_neg;
    logic [NW-1:0]         r_rem;
    logic [NW-1:0]         r_dsh;
    logic [QUOT_BITS-1:0]  r_q;
    logic [CW-1:0]         r_cnt;
    logic signed [VEL_BITS-1:0] r_lin_v, r_ang_v;

    logic signed [LW-1:0]  lo, span, a_term;
    logic signed [BW-1:0]  diff, b_term;
    logic [PULSE_BITS-1:0] x_sel;
    logic [TOP_BITS-1:0]   top_sel;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic [PW-1:0]         prod_abs;
    logic [NW-1:0]         rem_nxt;
    logic                  q_bit;
    logic                  rnz, big, dead, spin_hi, spin_lo;
    logic [QUOT_BITS-1:0]  mag;
    logic [VEL_BITS-1:0]   val;
    logic signed [VEL_BITS-1:0] res, vel_fin;
    logic [PULSE_BITS:0]   hi_sum, lo_sum;

    // calibration terms lo and span, shared by the limit and stick channels, and the selected stick's terms
    always_comb begin
        lo     = $signed(LW'(i_pulse_min)) - $signed(LW'(i_span_margin));
        span   = $signed(LW'(i_pulse_max)) - $signed(LW'(i_pulse_min))
               + $signed(LW'({i_span_margin, 1'b0}));
        a_term = $signed(LW'(r_limit)) - lo;
        x_sel  = r_sel ? r_turn : r_lin;
        top_sel = r_sel ? i_top_angular : i_top_linear;
        diff   = $signed(BW'(x_sel)) - BW'(lo);
        b_term = (diff <<< 1) - BW'(span);
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            C_SQ: begin
                mul_a = AW'(span);
                mul_b = BW'(span);
            end
            C_TA: begin
                mul_a = $signed(AW'(top_sel));
                mul_b = BW'(a_term);
            end
            default: begin
                mul_a = r_ta;
                mul_b = b_term;
            end
        endcase
    end

    rcpv_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (prod)
    );

    assign prod_abs = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);

    rcpv_div_step #(.NW(NW)) u_div_step (
        .i_rem (r_rem),
        .i_dsh (r_dsh),
        .o_rem (rem_nxt),
        .o_bit (q_bit)
    );

    // floor, saturation, dead band and spin override
    always_comb begin
        rnz  = |r_rem;
        mag  = {1'b0, r_q[QUOT_BITS-2:0]} + QUOT_BITS'(r_neg & rnz);
        big  = r_q[QUOT_BITS-1] | (mag > QUOT_BITS'(VEL_LIMIT));
        val  = big ? VEL_BITS'(VEL_LIMIT) : mag[VEL_BITS-1:0];
        res  = r_neg ? -$signed(val) : $signed(val);
        dead = (x_sel > i_dead_low) && (x_sel < i_dead_high);
        vel_fin = (r_span0 || dead) ? '0 : res;
        hi_sum  = {1'b0, i_pulse_mid} + {1'b0, i_pulse_max};
        lo_sum  = {1'b0, i_pulse_mid} + {1'b0, i_pulse_min};
        spin_hi = r_spin > hi_sum[PULSE_BITS:1];
        spin_lo = r_spin < lo_sum[PULSE_BITS:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_limit <= i_limit;
                        r_lin   <= i_lin;
                        r_turn  <= i_turn;
                        r_spin  <= i_spin;
                        r_sel   <= 1'b0;
                        r_state <= C_SQ;
                    end
                end
                C_SQ: begin
                    r_den   <= prod[DW-1:0];
                    r_span0 <= (span == '0);
                    r_state <= C_TA;
                end
                C_TA: begin
                    r_ta    <= prod[AW-1:0];
                    r_state <= C_NUM;
                end
                C_NUM: begin
                    r_neg   <= prod[PW-1];
                    r_rem   <= prod_abs[NW-1:0];
                    r_dsh   <= NW'({r_den, {(QUOT_BITS-1){1'b0}}});
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    r_rem <= rem_nxt;
                    r_q   <= {r_q[QUOT_BITS-2:0], q_bit};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(QUOT_BITS - 1)) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    if (!r_sel) begin
                        r_lin_v <= vel_fin;
                        r_sel   <= 1'b1;
                        r_state <= C_TA;
                    end else begin
                        if (spin_hi) begin
                            r_ang_v <= VEL_BITS'(SPIN_CENTI);
                            r_lin_v <= '0;
                        end else if (spin_lo) begin
                            r_ang_v <= -VEL_BITS'(SPIN_CENTI);
                            r_lin_v <= '0;
                        end else begin
                            r_ang_v <= vel_fin;
                        end
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_lin  = r_lin_v;
    assign o_ang  = r_ang_v;

endmodule

FILE: rtl/core/rc_pulse_to_velocity_command.sv
// radio-control pulse frame to velocity command
//
// i_in carries one frame of measured pulse widths per transaction (mode,
// speed limit, linear stick, turn stick, spin stick). o_out returns one
// transaction per frame: decoded mode, mode-change flag, velocity valid and
// signed linear / angular velocities in hundredths.
// calibration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. all channels share the one calibration set.
// a manual frame runs one squaring of the span, then per stick one
// multiply for the scaled limit, one for the numerator and 12 restoring
// divide steps, all through one shared multiplier and one divide step
// unit. stop and auto frames skip the arithmetic and go straight to the
// output register. i_in.ready is high only while the sequencer is idle,
// so a new frame is taken only after the last one has left the sequencer.
// o_out is a register: a new frame is accepted while a finished result
// still waits, and the next result is held in the sequencer until the
// receiver takes the old one.
// reset loads the default calibration, stored mode back to stop, and
// drops o_out.valid.
module rc_pulse_to_velocity_command import rcpv_pkg::*; #(
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    rcpv_in_if.sink                 i_in,
    rcpv_out_if.source              o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [PULSE_BITS-1:0]   i_cfg_data
);
    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_OUT
    } t_tstate;

    t_tstate r_state;

    // calibration registers
    logic [PULSE_BITS-1:0] r_pulse_min, r_pulse_max, r_pulse_mid;
    logic [PULSE_BITS-1:0] r_dead_low, r_dead_high;
    logic [TOP_BITS-1:0]   r_span_margin, r_top_linear, r_top_angular;

    // frame state
    t_mode r_last_mode;
    t_mode r_mode;
    logic  r_chg;

    // output register
    logic                       r_ovalid;
    t_mode                      r_o_mode;
    logic                       r_o_chg;
    logic                       r_o_vvalid;
    logic signed [VEL_BITS-1:0] r_o_lin, r_o_ang;

    logic  in_acc;
    logic  out_free;
    logic  core_done;
    logic  is_manual;
    t_mode dec_mode;
    logic signed [VEL_BITS-1:0] core_lin, core_ang;

    // mode switch: below band stop, inside band manual, above auto
    always_comb begin
        if (i_in.mode_pulse < r_dead_low) begin
            dec_mode = OP_STOP;
        end else if (i_in.mode_pulse <= r_dead_high) begin
            dec_mode = OP_MANUAL;
        end else begin
            dec_mode = OP_AUTO;
        end
    end

    assign i_in.ready = (r_state == T_IDLE);
    assign in_acc     = i_in.valid && (r_state == T_IDLE);
    assign out_free   = !r_ovalid || o_out.ready;
    assign is_manual  = (r_mode == OP_MANUAL);

    rcpv_core #(.PULSE_BITS(PULSE_BITS)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc && (dec_mode == OP_MANUAL)),
        .i_limit       (i_in.limit_pulse),
        .i_lin         (i_in.linear_pulse),
        .i_turn        (i_in.turn_pulse),
        .i_spin        (i_in.spin_pulse),
        .i_pulse_min   (r_pulse_min),
        .i_pulse_max   (r_pulse_max),
        .i_pulse_mid   (r_pulse_mid),
        .i_dead_low    (r_dead_low),
        .i_dead_high   (r_dead_high),
        .i_span_margin (r_span_margin),
        .i_top_linear  (r_top_linear),
        .i_top_angular (r_top_angular),
        .o_done        (core_done),
        .o_lin         (core_lin),
        .o_ang         (core_ang)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min   <= PULSE_BITS'(PULSE_MIN_RST);
            r_pulse_max   <= PULSE_BITS'(PULSE_MAX_RST);
            r_pulse_mid   <= PULSE_BITS'(PULSE_MID_RST);
            r_dead_low    <= PULSE_BITS'(DEAD_LOW_RST);
            r_dead_high   <= PULSE_BITS'(DEAD_HIGH_RST);
            r_span_margin <= TOP_BITS'(SPAN_MARGIN_RST);
            r_top_linear  <= TOP_BITS'(TOP_LINEAR_RST);
            r_top_angular <= TOP_BITS'(TOP_ANGULAR_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PULSE_MIN:   r_pulse_min   <= i_cfg_data;
                CFG_PULSE_MAX:   r_pulse_max   <= i_cfg_data;
                CFG_PULSE_MID:   r_pulse_mid   <= i_cfg_data;
                CFG_DEAD_LOW:    r_dead_low    <= i_cfg_data;
                CFG_DEAD_HIGH:   r_dead_high   <= i_cfg_data;
                CFG_SPAN_MARGIN: r_span_margin <= i_cfg_data[TOP_BITS-1:0];
                CFG_TOP_LINEAR:  r_top_linear  <= i_cfg_data[TOP_BITS-1:0];
                CFG_TOP_ANGULAR: r_top_angular <= i_cfg_data[TOP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // frame sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_last_mode <= OP_STOP;
            r_ovalid    <= 1'b0;
        end else begin
            // in T_OUT a result leaving this cycle is replaced below
            if (r_ovalid && o_out.ready && (r_state != T_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (in_acc) begin
                        r_mode      <= dec_mode;
                        r_chg       <= (dec_mode != r_last_mode);
                        r_last_mode <= dec_mode;
                        r_state     <= (dec_mode == OP_MANUAL) ? T_CALC : T_OUT;
                    end
                end
                T_CALC: begin
                    if (core_done) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_o_mode   <= r_mode;
                        r_o_chg    <= r_chg;
                        r_o_vvalid <= is_manual;
                        r_o_lin    <= is_manual ? core_lin : '0;
                        r_o_ang    <= is_manual ? core_ang : '0;
                        r_state    <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.op_mode        = r_o_mode;
    assign o_out.mode_changed   = r_o_chg;
    assign o_out.velocity_valid = r_o_vvalid;
    assign o_out.linear_centi   = r_o_lin;
    assign o_out.angular_centi  = r_o_ang;

endmodule

FILE: rtl/core/rcpv_chk.sv
module rcpv_chk import rcpv_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [1:0]                 i_op_mode,
    input logic                       i_velocity_valid,
    input logic signed [VEL_BITS-1:0] i_linear_centi,
    input logic signed [VEL_BITS-1:0] i_angular_centi
);
    // velocities are zero whenever the frame is not manual
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_velocity_valid) |->
            (i_linear_centi == '0) && (i_angular_centi == '0))
        else $error("velocity nonzero outside manual mode");

    // velocity valid follows the decoded mode
    a_valid_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_velocity_valid == (i_op_mode == OP_MANUAL)))
        else $error("velocity valid disagrees with mode");

    // saturation keeps both velocities in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_linear_centi <= VEL_BITS'(VEL_LIMIT)) &&
            (i_linear_centi >= -VEL_BITS'(VEL_LIMIT)) &&
            (i_angular_centi <= VEL_BITS'(VEL_LIMIT)) &&
            (i_angular_centi >= -VEL_BITS'(VEL_LIMIT)))
        else $error("velocity out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_linear_centi) && $stable(i_angular_centi))
        else $error("stalled result changed");
endmodule

bind rc_pulse_to_velocity_command rcpv_chk u_rcpv_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_op_mode        (o_out.op_mode),
    .i_velocity_valid (o_out.velocity_valid),
    .i_linear_centi   (o_out.linear_centi),
    .i_angular_centi  (o_out.angular_centi)
);
